// ===== rtl/hat_pkg.sv =====
// Shared types and constants for the heap-ordered binary tree traversal block.
// Used by hat_walk and heap_array_tree_traversal_top; depends on nothing else.
package hat_pkg;

  localparam int FUNC_W   = 4;
  localparam int SLOT_W   = 4;
  localparam int VAL_W    = 8;
  localparam int HEIGHT_W = 3;
  localparam int RUN_W    = 4;

  // A run of node values never holds more than this many transfers.
  localparam logic [RUN_W-1:0] MAX_RUN = 4'd15;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE  = 4'd0,
    FN_PRE    = 4'd1,
    FN_IN     = 4'd2,
    FN_POST   = 4'd3,
    FN_LEVEL  = 4'd4,
    FN_LEAVES = 4'd5,
    FN_HEIGHT = 4'd6,
    FN_MIN    = 4'd7,
    FN_MAX    = 4'd8,
    FN_SEARCH = 4'd9
  } func_e;

  typedef enum logic [1:0] {
    ORD_PRE,
    ORD_IN,
    ORD_POST
  } order_e;

  typedef struct packed {
    logic   start;
    logic   advance;
    order_e order;
  } walk_cmd_t;

endpackage

// ===== rtl/hat_walk.sv =====
// Depth-first walker over a heap-ordered tree, one move per advance.
// Depends on hat_pkg; the reachability vector comes from the top level.
module hat_walk #(
  parameter int LEVELS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [(1<<LEVELS)-1:0] reach_i,
  input  hat_pkg::walk_cmd_t    cmd_i,
  output logic [LEVELS-1:0]     node_o,
  output logic                  emit_o
);
  import hat_pkg::*;

  localparam int NSLOTS = (1 << LEVELS) - 1;
  localparam int IW     = LEVELS;
  localparam int CW     = LEVELS + 1;

  typedef enum logic [1:0] {
    PH_ARRIVE,
    PH_LEFT_DONE,
    PH_RIGHT_DONE
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [IW-1:0]   node_q, node_d;
  logic [CW-1:0]   left_c, right_c;
  logic [IW-1:0]   parent_c;
  logic            left_ok, right_ok;

  assign left_c   = {node_q, 1'b1};
  assign right_c  = {node_q, 1'b0} + CW'(2);
  assign parent_c = (node_q - IW'(1)) >> 1;
  assign left_ok  = (left_c < CW'(NSLOTS)) && reach_i[left_c[IW-1:0]];
  assign right_ok = (right_c < CW'(NSLOTS)) && reach_i[right_c[IW-1:0]];

  assign node_o = node_q;

  // A node is visited three times; the order picks the visit that emits it.
  always_comb begin
    unique case (phase_q)
      PH_ARRIVE:     emit_o = (cmd_i.order == ORD_PRE);
      PH_LEFT_DONE:  emit_o = (cmd_i.order == ORD_IN);
      PH_RIGHT_DONE: emit_o = (cmd_i.order == ORD_POST);
      default:       emit_o = 1'b0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    node_d  = node_q;
    if (cmd_i.start) begin
      phase_d = PH_ARRIVE;
      node_d  = '0;
    end else if (cmd_i.advance) begin
      unique case (phase_q)
        PH_ARRIVE: begin
          if (left_ok) begin
            node_d = left_c[IW-1:0];
          end else begin
            phase_d = PH_LEFT_DONE;
          end
        end
        PH_LEFT_DONE: begin
          if (right_ok) begin
            node_d  = right_c[IW-1:0];
            phase_d = PH_ARRIVE;
          end else begin
            phase_d = PH_RIGHT_DONE;
          end
        end
        PH_RIGHT_DONE: begin
          // Climbing from a left child resumes at the parent's in-order visit.
          if (node_q != '0) begin
            node_d  = parent_c;
            phase_d = node_q[0] ? PH_LEFT_DONE : PH_RIGHT_DONE;
          end
        end
        default: phase_d = PH_ARRIVE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ARRIVE;
      node_q  <= '0;
    end else begin
      phase_q <= phase_d;
      node_q  <= node_d;
    end
  end

endmodule

// ===== rtl/heap_array_tree_traversal_top.sv =====
// Top level of the heap-ordered binary tree traversal block: slot store, scan and run control.
// Depends on hat_pkg and instantiates hat_walk.
//
// The block holds a binary tree of 2^LEVELS-1 slots in heap order (slot i has children 2i+1
// and 2i+2); node values live in a synchronous single-read-port memory and the present bits
// in flip-flops that reset clears, so the tree is empty after reset and no clearing pass is
// needed. A write item yields no transfer; out-of-range slots and unknown function codes
// are accepted and ignored. Every query first scans the memory in slot order, one slot per
// cycle, gathering node and leaf counts, height, minimum, maximum and the search hit.
// Height, minimum, maximum and search then give a single transfer. A run in slot order or
// of leaves follows with a second pass of one slot per cycle unless a stall on the output
// holds it; a preorder, inorder or postorder run is produced by the walker at one move per
// cycle, under the same condition. A node counts only when it and all its ancestors are
// present. Runs are cut at fifteen transfers, and the last flag marks the final one. Input
// is taken only while the block is idle; one result waits in the output register while
// the next work proceeds, and a stall on the output simply holds the run where it stands.
module heap_array_tree_traversal_top #(
  parameter int LEVELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [hat_pkg::FUNC_W-1:0]    func_i,
  input  logic [hat_pkg::SLOT_W-1:0]    slot_i,
  input  logic [hat_pkg::VAL_W-1:0]     node_value_i,
  input  logic                          node_present_i,
  input  logic [hat_pkg::VAL_W-1:0]     search_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [hat_pkg::VAL_W-1:0]     value_o,
  output logic                          last_o,
  output logic                          empty_tree_o,
  output logic                          found_o,
  output logic [hat_pkg::HEIGHT_W-1:0]  height_o
);
  import hat_pkg::*;

  localparam int NSLOTS = (1 << LEVELS) - 1;
  localparam int NPAD   = 1 << LEVELS;
  localparam int IW     = LEVELS;
  localparam int CW     = LEVELS + 1;
  localparam int LW     = $clog2(LEVELS + 1);
  localparam int XW     = ((LEVELS > SLOT_W) ? LEVELS : SLOT_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_EMIT_SLOT,
    S_EMIT_WALK,
    S_FLUSH
  } state_e;

  // Node values: written by write items, read at most once per cycle during scans and runs.
  logic [VAL_W-1:0] slot_mem [NSLOTS];

  state_e            state_q, state_d;
  func_e             func_q, func_d;
  logic [VAL_W-1:0]  want_q, want_d;
  logic [NSLOTS-1:0] occ_q, occ_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [LW-1:0]     hgt_q, hgt_d;
  logic [RUN_W-1:0]  cnt_all_q, cnt_all_d;
  logic [RUN_W-1:0]  cnt_leaf_q, cnt_leaf_d;
  logic [RUN_W-1:0]  total_q, total_d;
  logic [RUN_W-1:0]  k_q, k_d;
  logic [VAL_W-1:0]  min_q, min_d;
  logic [VAL_W-1:0]  max_q, max_d;
  logic              hit_q, hit_d;
  logic              dv_q, dv_d;
  logic              dreach_q, dreach_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic [VAL_W-1:0]  rdata_q;

  logic                out_valid_q, out_valid_d;
  logic [VAL_W-1:0]    out_value_q, out_value_d;
  logic                out_last_q, out_last_d;
  logic                out_empty_q, out_empty_d;
  logic                out_found_q, out_found_d;
  logic [HEIGHT_W-1:0] out_height_q, out_height_d;

  logic [NPAD-1:0]      reach_c;
  logic                 in_acc;
  logic [XW-1:0]        slot_x;
  logic                 wr_ok;
  logic [IW-1:0]        wr_addr;
  logic                 mem_we;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic                 out_load_ok;
  logic                 go;
  logic                 issue;
  logic [IW-1:0]        issue_addr;
  logic                 empty_c;
  logic                 cand;
  logic [CW-1:0]        nxt_c;
  logic [RUN_W-1:0]     run_total;
  logic [LW+HEIGHT_W-1:0] hgt_ext;
  walk_cmd_t            walk_cmd;
  logic [IW-1:0]        walk_node;
  logic                 walk_emit;

  // A slot is reachable when it is present and so is every slot above it.
  assign reach_c[0] = occ_q[0];
  for (genvar gi = 1; gi < NSLOTS; gi++) begin : g_reach
    assign reach_c[gi] = occ_q[gi] & reach_c[(gi - 1) / 2];
  end
  assign reach_c[NPAD-1] = 1'b0;

  function automatic logic leaf_f(input logic [NPAD-1:0] r, input logic [IW-1:0] idx);
    logic [CW-1:0] lc;
    logic [CW-1:0] rc;
    lc = {idx, 1'b1};
    rc = {idx, 1'b0} + CW'(2);
    return r[idx] && !((lc < CW'(NSLOTS)) && r[lc[IW-1:0]])
                  && !((rc < CW'(NSLOTS)) && r[rc[IW-1:0]]);
  endfunction

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_x      = XW'(slot_i);
  assign wr_ok       = (slot_x < XW'(NSLOTS));
  assign wr_addr     = slot_x[IW-1:0];
  assign mem_we      = in_acc && (func_i == FN_WRITE) && wr_ok;
  assign empty_c     = !reach_c[0];
  assign out_load_ok = !out_valid_q || !out_stall_i;
  // A new read may only be issued once the value already read has somewhere to go.
  assign go          = !pend_q || out_load_ok;
  assign nxt_c       = CW'(idx_q) + CW'(1);
  assign run_total   = (func_q == FN_LEAVES) ? cnt_leaf_q : cnt_all_q;
  assign hgt_ext     = (LW + HEIGHT_W)'(hgt_q);

  hat_walk #(
    .LEVELS (LEVELS)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .reach_i (reach_c),
    .cmd_i   (walk_cmd),
    .node_o  (walk_node),
    .emit_o  (walk_emit)
  );

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    want_d       = want_q;
    occ_d        = occ_q;
    idx_d        = idx_q;
    lvl_d        = lvl_q;
    hgt_d        = hgt_q;
    cnt_all_d    = cnt_all_q;
    cnt_leaf_d   = cnt_leaf_q;
    total_d      = total_q;
    k_d          = k_q;
    min_d        = min_q;
    max_d        = max_q;
    hit_d        = hit_q;
    dv_d         = 1'b0;
    dreach_d     = 1'b0;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    out_found_d  = out_found_q;
    out_height_d = out_height_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q;
    issue        = 1'b0;
    issue_addr   = idx_q;
    cand         = 1'b0;
    walk_cmd.start   = 1'b0;
    walk_cmd.advance = 1'b0;
    walk_cmd.order   = (func_q == FN_IN)   ? ORD_IN :
                       (func_q == FN_POST) ? ORD_POST : ORD_PRE;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // The value read for a run moves into the output register as soon as it is free.
    if (pend_q && out_load_ok) begin
      out_valid_d  = 1'b1;
      out_value_d  = rdata_q;
      out_last_d   = pend_last_q;
      out_empty_d  = 1'b0;
      out_found_d  = 1'b0;
      out_height_d = '0;
      pend_d       = 1'b0;
    end

    // Second half of the scan: the value read last cycle updates min, max and search.
    if (dv_q && dreach_q) begin
      if (rdata_q < min_q) begin
        min_d = rdata_q;
      end
      if (rdata_q > max_q) begin
        max_d = rdata_q;
      end
      if (rdata_q == want_q) begin
        hit_d = 1'b1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func_e'(func_i))
            FN_WRITE: begin
              if (wr_ok) begin
                occ_d[wr_addr] = node_present_i;
              end
            end
            FN_PRE, FN_IN, FN_POST, FN_LEVEL, FN_LEAVES,
            FN_HEIGHT, FN_MIN, FN_MAX, FN_SEARCH: begin
              func_d     = func_e'(func_i);
              want_d     = search_value_i;
              idx_d      = '0;
              lvl_d      = '0;
              hgt_d      = '0;
              cnt_all_d  = '0;
              cnt_leaf_d = '0;
              min_d      = '1;
              max_d      = '0;
              hit_d      = 1'b0;
              state_d    = S_SCAN;
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        rd_en    = 1'b1;
        rd_addr  = idx_q;
        dv_d     = 1'b1;
        dreach_d = reach_c[idx_q];
        if (reach_c[idx_q]) begin
          hgt_d = lvl_q + LW'(1);
          if (cnt_all_q != MAX_RUN) begin
            cnt_all_d = cnt_all_q + RUN_W'(1);
          end
          if (leaf_f(reach_c, idx_q) && (cnt_leaf_q != MAX_RUN)) begin
            cnt_leaf_d = cnt_leaf_q + RUN_W'(1);
          end
        end
        if (idx_q == IW'(NSLOTS - 1)) begin
          state_d = S_SCAN_END;
        end else begin
          idx_d = nxt_c[IW-1:0];
          // The first slot of each level has an index of the form 2^n - 1.
          if ((nxt_c & (nxt_c + CW'(1))) == '0) begin
            lvl_d = lvl_q + LW'(1);
          end
        end
      end

      S_SCAN_END: begin
        state_d = S_DECIDE;
      end

      S_DECIDE: begin
        total_d = run_total;
        if ((func_q == FN_PRE || func_q == FN_IN || func_q == FN_POST ||
             func_q == FN_LEVEL || func_q == FN_LEAVES) && (run_total != '0)) begin
          k_d   = '0;
          idx_d = '0;
          if (func_q == FN_LEVEL || func_q == FN_LEAVES) begin
            state_d = S_EMIT_SLOT;
          end else begin
            walk_cmd.start = 1'b1;
            state_d        = S_EMIT_WALK;
          end
        end else if (out_load_ok) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_empty_d  = empty_c;
          out_value_d  = '0;
          out_found_d  = 1'b0;
          out_height_d = '0;
          if (!empty_c && func_q == FN_MIN) begin
            out_value_d = min_q;
          end
          if (!empty_c && func_q == FN_MAX) begin
            out_value_d = max_q;
          end
          if (func_q == FN_SEARCH) begin
            out_found_d = hit_q;
          end
          if (func_q == FN_HEIGHT) begin
            out_height_d = hgt_ext[HEIGHT_W-1:0];
          end
          state_d = S_IDLE;
        end
      end

      S_EMIT_SLOT: begin
        if (go) begin
          cand  = (func_q == FN_LEVEL) ? reach_c[idx_q] : leaf_f(reach_c, idx_q);
          issue = cand;
          issue_addr = idx_q;
          idx_d = nxt_c[IW-1:0];
        end
      end

      S_EMIT_WALK: begin
        walk_cmd.advance = go;
        if (go && walk_emit) begin
          issue      = 1'b1;
          issue_addr = walk_node;
        end
      end

      S_FLUSH: begin
        if (!pend_q || out_load_ok) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // One node of a run: read it now, hand it to the output register once that is free.
    if (issue) begin
      rd_en       = 1'b1;
      rd_addr     = issue_addr;
      pend_d      = 1'b1;
      pend_last_d = (k_q == total_q - RUN_W'(1));
      k_d         = k_q + RUN_W'(1);
      if (k_q == total_q - RUN_W'(1)) begin
        state_d = S_FLUSH;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= node_value_i;
    end
    if (rd_en) begin
      rdata_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      func_q       <= FN_WRITE;
      want_q       <= '0;
      occ_q        <= '0;
      idx_q        <= '0;
      lvl_q        <= '0;
      hgt_q        <= '0;
      cnt_all_q    <= '0;
      cnt_leaf_q   <= '0;
      total_q      <= '0;
      k_q          <= '0;
      min_q        <= '0;
      max_q        <= '0;
      hit_q        <= 1'b0;
      dv_q         <= 1'b0;
      dreach_q     <= 1'b0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_last_q   <= 1'b0;
      out_empty_q  <= 1'b0;
      out_found_q  <= 1'b0;
      out_height_q <= '0;
    end else begin
      state_q      <= state_d;
      func_q       <= func_d;
      want_q       <= want_d;
      occ_q        <= occ_d;
      idx_q        <= idx_d;
      lvl_q        <= lvl_d;
      hgt_q        <= hgt_d;
      cnt_all_q    <= cnt_all_d;
      cnt_leaf_q   <= cnt_leaf_d;
      total_q      <= total_d;
      k_q          <= k_d;
      min_q        <= min_d;
      max_q        <= max_d;
      hit_q        <= hit_d;
      dv_q         <= dv_d;
      dreach_q     <= dreach_d;
      pend_q       <= pend_d;
      pend_last_q  <= pend_last_d;
      out_valid_q  <= out_valid_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
      out_empty_q  <= out_empty_d;
      out_found_q  <= out_found_d;
      out_height_q <= out_height_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = out_value_q;
  assign last_o       = out_last_q;
  assign empty_tree_o = out_empty_q;
  assign found_o      = out_found_q;
  assign height_o     = out_height_q;

  // No value read for a run may be left behind when the block goes idle.
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("pending run value while idle");

  // A value waiting for a free output register must not be overwritten by a new read.
  a_hold_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && out_valid_q && out_stall_i) |=> $stable(rdata_q))
    else $error("read data changed under a pending run value");

  // A run never issues more reads than the count gathered by the scan.
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_SLOT || state_q == S_EMIT_WALK) |-> (k_q < total_q))
    else $error("run issued beyond its node count");

  // A single-transfer answer always closes its item.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (found_o || empty_tree_o || height_o != '0)) |-> last_o)
    else $error("single result without last flag");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for heap_array_tree_traversal_top: directed and random write and
// query items, with a predictor of the tree store. Depends on hat_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hat_pkg::*;

  localparam int TREE_LEVELS = 4;
  localparam int NUM_SLOTS = (1 << TREE_LEVELS) - 1;
  // A query scans the store once and a run then walks its nodes, so this many quiet cycles
  // are more than enough for the block to settle.
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS = 90;

  // Function codes beyond the last defined one, which the block must ignore.
  localparam logic [FUNC_W-1:0] FN_UNKNOWN_FIRST = FUNC_W'(FN_SEARCH + 1);
  localparam logic [FUNC_W-1:0] FN_UNKNOWN_LAST = '1;
  // The one slot index that the four-bit field can carry but the store does not have.
  localparam logic [SLOT_W-1:0] SLOT_OUT_OF_RANGE = '1;

  typedef struct packed {
    logic [VAL_W-1:0]    value;
    logic                last;
    logic                empty_tree;
    logic                found;
    logic [HEIGHT_W-1:0] height;
  } tree_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i;
  logic [SLOT_W-1:0]   slot_i;
  logic [VAL_W-1:0]    node_value_i;
  logic                node_present_i;
  logic [VAL_W-1:0]    search_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [VAL_W-1:0]    value_o;
  logic                last_o;
  logic                empty_tree_o;
  logic                found_o;
  logic [HEIGHT_W-1:0] height_o;

  heap_array_tree_traversal_top #(
    .LEVELS(TREE_LEVELS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .slot_i         (slot_i),
    .node_value_i   (node_value_i),
    .node_present_i (node_present_i),
    .search_value_i (search_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_o        (value_o),
    .last_o         (last_o),
    .empty_tree_o   (empty_tree_o),
    .found_o        (found_o),
    .height_o       (height_o)
  );

  // Shadow copy of the tree. Values start at zero here, but the stimulus never reads a slot
  // that has not been written, since only a write can mark a slot present.
  bit [VAL_W-1:0] tree_value [NUM_SLOTS];
  bit             tree_present [NUM_SLOTS];
  bit             reachable [NUM_SLOTS];
  bit [VAL_W-1:0] run_values [$];

  tree_result_t expected_results [$];
  int           error_count = 0;
  // When set, neither side inserts idle cycles, which gives back-to-back transfers.
  bit           no_idle = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // A node counts only when it is present and every one of its ancestors is present too.
  function automatic void mark_reachable();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      reachable[i] = tree_present[i] && (i == 0 || reachable[(i - 1) / 2]);
    end
  endfunction

  function automatic bit is_reachable(int i);
    if (i >= NUM_SLOTS) return 1'b0;
    return reachable[i];
  endfunction

  // Runs are cut at the block's maximum run length; later nodes are simply dropped.
  function automatic void add_to_run(bit [VAL_W-1:0] v);
    if (run_values.size() < MAX_RUN) run_values.push_back(v);
  endfunction

  function automatic void walk_tree(int i, order_e ord);
    if (!is_reachable(i)) return;
    if (ord == ORD_PRE) add_to_run(tree_value[i]);
    walk_tree(2 * i + 1, ord);
    if (ord == ORD_IN) add_to_run(tree_value[i]);
    walk_tree(2 * i + 2, ord);
    if (ord == ORD_POST) add_to_run(tree_value[i]);
  endfunction

  function automatic void expect_result(logic [VAL_W-1:0] v, logic last, logic empty,
                                        logic hit, logic [HEIGHT_W-1:0] h);
    tree_result_t r;
    r.value      = v;
    r.last       = last;
    r.empty_tree = empty;
    r.found      = hit;
    r.height     = h;
    expected_results.push_back(r);
  endfunction

  // Applies one accepted item to the shadow tree and queues the transfers it must cause.
  function automatic void predict_tree_item(logic [FUNC_W-1:0] fn, logic [SLOT_W-1:0] slot,
                                            logic [VAL_W-1:0] nval, logic npres,
                                            logic [VAL_W-1:0] sval);
    int  best;
    int  h;
    int  lvl;
    int  n;
    bit  empty;
    bit  hit;
    if (fn == FN_WRITE) begin
      if (slot < NUM_SLOTS) begin
        tree_value[slot]   = nval;
        tree_present[slot] = npres;
      end
      return;
    end
    if (fn > FN_SEARCH) return;
    mark_reachable();
    empty = !reachable[0];
    run_values.delete();
    case (fn)
      FN_PRE:  walk_tree(0, ORD_PRE);
      FN_IN:   walk_tree(0, ORD_IN);
      FN_POST: walk_tree(0, ORD_POST);
      FN_LEVEL, FN_LEAVES: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (reachable[i] && (fn == FN_LEVEL ||
              (!is_reachable(2 * i + 1) && !is_reachable(2 * i + 2)))) begin
            add_to_run(tree_value[i]);
          end
        end
      end
      FN_HEIGHT: begin
        h = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (reachable[i]) begin
            lvl = 0;
            n = i + 1;
            while (n > 1) begin
              n = n >> 1;
              lvl++;
            end
            if (lvl + 1 > h) h = lvl + 1;
          end
        end
        expect_result('0, 1'b1, empty, 1'b0, h[HEIGHT_W-1:0]);
      end
      FN_MIN, FN_MAX: begin
        best = (fn == FN_MIN) ? 255 : 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (reachable[i] && ((fn == FN_MIN) ? (tree_value[i] < best)
                                              : (tree_value[i] > best))) begin
            best = tree_value[i];
          end
        end
        expect_result(empty ? '0 : best[VAL_W-1:0], 1'b1, empty, 1'b0, '0);
      end
      default: begin
        hit = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (reachable[i] && tree_value[i] == sval) hit = 1'b1;
        end
        expect_result('0, 1'b1, empty, hit, '0);
      end
    endcase
    if (fn >= FN_PRE && fn <= FN_LEAVES) begin
      if (run_values.size() == 0) begin
        expect_result('0, 1'b1, 1'b1, 1'b0, '0);
      end else begin
        foreach (run_values[k]) begin
          expect_result(run_values[k], k == run_values.size() - 1, 1'b0, 1'b0, '0);
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driving the input channel
  // ---------------------------------------------------------------------------------------

  // Offers one item and returns straight after the edge at which it was transferred. The
  // valid is left high, so that an item following with no gap keeps it high without a dip;
  // the payload only changes once the previous transfer has happened.
  task automatic send_item(logic [FUNC_W-1:0] fn, logic [SLOT_W-1:0] slot,
                           logic [VAL_W-1:0] nval, logic npres, logic [VAL_W-1:0] sval);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    slot_i         <= slot;
    node_value_i   <= nval;
    node_present_i <= npres;
    search_value_i <= sval;
    do @(posedge clk_i); while (in_stall_o);
    predict_tree_item(fn, slot, nval, npres, sval);
  endtask

  // Fields that a write does not use are filled with random bits.
  task automatic write_slot(logic [SLOT_W-1:0] slot, logic [VAL_W-1:0] nval, logic npres);
    send_item(FN_WRITE, slot, nval, npres, VAL_W'($urandom));
  endtask

  task automatic query_tree(logic [FUNC_W-1:0] fn, logic [VAL_W-1:0] sval);
    send_item(fn, SLOT_W'($urandom), VAL_W'($urandom), 1'($urandom), sval);
  endtask

  // Holds the sender off until every expected transfer has come, then lets the block settle
  // in case the last item was a write or an ignored code that is still in flight.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Straight after reset the tree is empty: every query must flag it, and unknown function
  // codes must give nothing at all.
  task automatic test_empty_tree();
    for (int f = FN_PRE; f <= FN_SEARCH; f++) begin
      query_tree(f[FUNC_W-1:0], VAL_W'($urandom));
    end
    query_tree(FN_UNKNOWN_FIRST, VAL_W'($urandom));
    query_tree(FN_UNKNOWN_LAST, VAL_W'($urandom));
  endtask

  // A small tree with the value extremes, a present node hidden under an empty parent, and a
  // write to the slot index that lies outside the store.
  task automatic test_sparse_tree();
    write_slot(4'd0, 8'hFF, 1'b1);
    write_slot(4'd2, 8'h00, 1'b1);
    write_slot(4'd3, 8'h5A, 1'b1);
    write_slot(SLOT_OUT_OF_RANGE, 8'h01, 1'b1);
    for (int f = FN_PRE; f <= FN_MAX; f++) begin
      query_tree(f[FUNC_W-1:0], VAL_W'($urandom));
    end
    // The unreachable node must not be found; the reachable zero must be.
    query_tree(FN_SEARCH, 8'h5A);
    query_tree(FN_SEARCH, 8'h00);
    // Removing the root hides every node below it.
    write_slot(4'd0, 8'h80, 1'b0);
    query_tree(FN_MIN, VAL_W'($urandom));
    wait_for_drain();
  endtask

  // Random mix: whole trees rebuilt now and then, single writes that grow or prune the tree,
  // queries of every kind, and a little noise with unknown function codes.
  task automatic test_random_trees();
    int items_sent;
    int slot_pick;
    bit all_present;
    logic [VAL_W-1:0] sval;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
      case ($urandom_range(0, 9))
        0: begin
          all_present = 1'($urandom_range(0, 1));
          for (int s = 0; s < NUM_SLOTS; s++) begin
            write_slot(s[SLOT_W-1:0], VAL_W'($urandom),
                       all_present || ($urandom_range(0, 7) != 0));
          end
          items_sent += NUM_SLOTS;
        end
        1, 2, 3, 4: begin
          write_slot(SLOT_W'($urandom_range(0, NUM_SLOTS)), VAL_W'($urandom),
                     $urandom_range(0, 5) != 0);
          items_sent++;
        end
        5, 6, 7, 8: begin
          // Half of the time the search value is taken from the picked slot, if that slot is present.
          slot_pick = $urandom_range(0, NUM_SLOTS - 1);
          sval = VAL_W'($urandom);
          if ($urandom_range(0, 1) && tree_present[slot_pick]) sval = tree_value[slot_pick];
          query_tree(FUNC_W'($urandom_range(FN_PRE, FN_SEARCH)), sval);
          items_sent++;
        end
        default: begin
          send_item(FUNC_W'($urandom_range(FN_UNKNOWN_FIRST, FN_UNKNOWN_LAST)),
                    SLOT_W'($urandom), VAL_W'($urandom), 1'($urandom), VAL_W'($urandom));
          items_sent++;
        end
      endcase
      if ($urandom_range(0, 39) == 0) wait_for_drain();
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Output channel: the receiver stalls for a random number of cycles before each transfer.
  // ---------------------------------------------------------------------------------------
  initial begin
    int hold;
    out_stall_i <= 1'b0;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Every result transfer is matched against the oldest expectation, field by field.
  always @(posedge clk_i) begin : check_results
    tree_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transfer, actual value %0d last %0b", $time, value_o,
                 last_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("value", want.value, value_o);
        check_field("last", want.last, last_o);
        check_field("empty_tree", want.empty_tree, empty_tree_o);
        check_field("found", want.found, found_o);
        check_field("height", want.height, height_o);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------------------
  initial begin
    in_valid_i     <= 1'b0;
    func_i         <= FN_WRITE;
    slot_i         <= '0;
    node_value_i   <= '0;
    node_present_i <= 1'b0;
    search_value_i <= '0;
    rst_ni         <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_tree();
    test_sparse_tree();
    test_random_trees();
    wait_for_drain();
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // The slowest correct run takes well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
